FILE: sv/pli_pkg.sv
// Shared constants, codes and controller/datapath types of the posting list intersection unit.
package pli_pkg;

    localparam int CAPACITY = 32;
    localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int ID_W     = 32;
    localparam int REQ_W    = 2;

    typedef enum logic [REQ_W-1:0] {
        REQ_ELEM      = 2'd0,
        REQ_END_LIST  = 2'd1,
        REQ_END_QUERY = 2'd2
    } t_req;

    localparam logic KIND_ID    = 1'b0;
    localparam logic KIND_COUNT = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DECIDE,
        ST_OUT_ID,
        ST_OUT_CNT
    } t_state;

    typedef struct packed {
        logic elem;
        logic end_list;
        logic scan_init;
        logic scan_step;
        logic scan_restart;
        logic load_id;
        logic load_count;
        logic clear;
    } t_cmd;

    typedef struct packed {
        logic idx_last;
        logic found;
    } t_sts;

endpackage

FILE: sv/pli_req_if.sv
// Request channel interface carrying list elements and markers.
interface pli_req_if;
    logic                        valid;
    logic                        ready;
    logic [pli_pkg::REQ_W-1:0]   req_type;
    logic [pli_pkg::ID_W-1:0]    doc_id;

    modport source (output valid, output req_type, output doc_id, input ready);
    modport sink   (input valid, input req_type, input doc_id, output ready);
endinterface

FILE: sv/pli_res_if.sv
// Result channel interface carrying surviving ids and the count item.
interface pli_res_if;
    logic                     valid;
    logic                     ready;
    logic                     out_kind;
    logic [pli_pkg::ID_W-1:0] out_value;
    logic                     overflowed;
    logic                     run_end;

    modport source (output valid, output out_kind, output out_value, output overflowed,
                    output run_end, input ready);
    modport sink   (input valid, input out_kind, input out_value, input overflowed,
                    input run_end, output ready);
endinterface

FILE: sv/pli_ctrl.sv
// Controller state machine that sequences element updates and the ordered emission.
module pli_ctrl (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_in_valid,
    input  logic [pli_pkg::REQ_W-1:0] i_req_type,
    output logic                      o_in_ready,
    output logic                      o_out_valid,
    input  logic                      i_out_ready,
    output pli_pkg::t_cmd             o_cmd,
    input  pli_pkg::t_sts             i_sts
);

    pli_pkg::t_state r_state;
    pli_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= pli_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state     = r_state;
        o_cmd       = '0;
        o_in_ready  = 1'b0;
        o_out_valid = 1'b0;
        unique case (r_state)
            pli_pkg::ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    unique case (i_req_type)
                        pli_pkg::REQ_ELEM:     o_cmd.elem = 1'b1;
                        pli_pkg::REQ_END_LIST: o_cmd.end_list = 1'b1;
                        pli_pkg::REQ_END_QUERY: begin
                            o_cmd.scan_init = 1'b1;
                            n_state         = pli_pkg::ST_SCAN;
                        end
                        default: ;
                    endcase
                end
            end
            pli_pkg::ST_SCAN: begin
                o_cmd.scan_step = 1'b1;
                if (i_sts.idx_last) begin
                    n_state = pli_pkg::ST_DECIDE;
                end
            end
            pli_pkg::ST_DECIDE: begin
                if (i_sts.found) begin
                    o_cmd.load_id = 1'b1;
                    n_state       = pli_pkg::ST_OUT_ID;
                end else begin
                    o_cmd.load_count = 1'b1;
                    n_state          = pli_pkg::ST_OUT_CNT;
                end
            end
            pli_pkg::ST_OUT_ID: begin
                o_out_valid = 1'b1;
                if (i_out_ready) begin
                    o_cmd.scan_restart = 1'b1;
                    n_state            = pli_pkg::ST_SCAN;
                end
            end
            pli_pkg::ST_OUT_CNT: begin
                o_out_valid = 1'b1;
                if (i_out_ready) begin
                    o_cmd.clear = 1'b1;
                    n_state     = pli_pkg::ST_IDLE;
                end
            end
            default: n_state = pli_pkg::ST_IDLE;
        endcase
    end

endmodule

FILE: sv/pli_dp.sv
// Datapath with the id store, parallel matchers, emission scan and result register.
module pli_dp (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic [pli_pkg::ID_W-1:0] i_doc_id,
    input  pli_pkg::t_cmd            i_cmd,
    output pli_pkg::t_sts            o_sts,
    output logic                     o_out_kind,
    output logic [pli_pkg::ID_W-1:0] o_out_value,
    output logic                     o_overflowed,
    output logic                     o_run_end
);

    localparam int CAP = pli_pkg::CAPACITY;

    logic [pli_pkg::ID_W-1:0]  r_value [CAP];
    logic [CAP-1:0]            r_valid;
    logic [CAP-1:0]            r_hit;
    logic                      r_first_done;
    logic                      r_ovf;

    logic [pli_pkg::IDX_W-1:0] r_idx;
    logic [pli_pkg::ID_W-1:0]  r_best;
    logic                      r_found;
    logic [pli_pkg::ID_W-1:0]  r_last;
    logic                      r_first;
    logic [pli_pkg::CNT_W-1:0] r_count;

    logic                      r_out_kind;
    logic [pli_pkg::ID_W-1:0]  r_out_value;
    logic                      r_out_ovf;
    logic                      r_out_end;

    logic [CAP-1:0]            eq_vec;
    logic                      free_ok;
    logic [pli_pkg::IDX_W-1:0] free_idx;
    logic [pli_pkg::ID_W-1:0]  scan_val;
    logic                      scan_cand;
    logic                      store_new;

    always_comb begin
        for (int i = 0; i < CAP; i++) begin
            eq_vec[i] = r_valid[i] && (r_value[i] == i_doc_id);
        end
    end

    always_comb begin
        free_ok  = 1'b0;
        free_idx = '0;
        for (int i = CAP - 1; i >= 0; i--) begin
            if (!r_valid[i]) begin
                free_ok  = 1'b1;
                free_idx = pli_pkg::IDX_W'(i);
            end
        end
    end

    assign store_new = i_cmd.elem && !r_first_done && !(|eq_vec) && free_ok;

    assign scan_val  = r_value[r_idx];
    assign scan_cand = r_valid[r_idx] && (r_first || (scan_val > r_last))
                       && (!r_found || (scan_val < r_best));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid      <= '0;
            r_hit        <= '0;
            r_first_done <= 1'b0;
            r_ovf        <= 1'b0;
        end else if (i_cmd.clear) begin
            r_valid      <= '0;
            r_hit        <= '0;
            r_first_done <= 1'b0;
            r_ovf        <= 1'b0;
        end else if (i_cmd.elem) begin
            if (!r_first_done) begin
                if (store_new) begin
                    r_valid[free_idx] <= 1'b1;
                    r_hit[free_idx]   <= 1'b0;
                end else if (!(|eq_vec)) begin
                    r_ovf <= 1'b1;
                end
            end else begin
                r_hit <= r_hit | eq_vec;
            end
        end else if (i_cmd.end_list) begin
            if (r_first_done) begin
                r_valid <= r_valid & r_hit;
            end
            r_hit        <= '0;
            r_first_done <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (store_new) begin
            r_value[free_idx] <= i_doc_id;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.scan_init || i_cmd.scan_restart) begin
            r_idx   <= '0;
            r_found <= 1'b0;
        end else if (i_cmd.scan_step) begin
            r_idx <= r_idx + pli_pkg::IDX_W'(1);
            if (scan_cand) begin
                r_best  <= scan_val;
                r_found <= 1'b1;
            end
        end
        if (i_cmd.scan_init) begin
            r_first <= 1'b1;
            r_count <= '0;
        end else if (i_cmd.load_id) begin
            r_first <= 1'b0;
            r_last  <= r_best;
            r_count <= r_count + pli_pkg::CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_id) begin
            r_out_kind  <= pli_pkg::KIND_ID;
            r_out_value <= r_best;
            r_out_ovf   <= r_ovf;
            r_out_end   <= 1'b0;
        end else if (i_cmd.load_count) begin
            r_out_kind  <= pli_pkg::KIND_COUNT;
            r_out_value <= pli_pkg::ID_W'(r_count);
            r_out_ovf   <= r_ovf;
            r_out_end   <= 1'b1;
        end
    end

    assign o_sts.idx_last = (r_idx == pli_pkg::IDX_W'(CAP - 1));
    assign o_sts.found    = r_found;
    assign o_out_kind     = r_out_kind;
    assign o_out_value    = r_out_value;
    assign o_overflowed   = r_out_ovf;
    assign o_run_end      = r_out_end;

endmodule

FILE: sv/posting_list_intersection_unit.sv
// In the idle state a new item (list element or end-of-list marker) is accepted every cycle.
// An end-of-query marker walks the store once per result: a scan of all CAPACITY entries, then
// a decision state, comes before each id or count item, with the minimum search checking one
// entry per cycle; no item is taken meanwhile.
// Synchronous active-low reset clears the valid and hit bits, the list flags and the controller.
module posting_list_intersection_unit (
    input  logic   i_clk,
    input  logic   i_rst_n,
    pli_req_if.sink   i_req,
    pli_res_if.source o_res
);

    pli_pkg::t_cmd cmd;
    pli_pkg::t_sts sts;

    pli_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_req.valid),
        .i_req_type  (i_req.req_type),
        .o_in_ready  (i_req.ready),
        .o_out_valid (o_res.valid),
        .i_out_ready (o_res.ready),
        .o_cmd       (cmd),
        .i_sts       (sts)
    );

    pli_dp u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_doc_id     (i_req.doc_id),
        .i_cmd        (cmd),
        .o_sts        (sts),
        .o_out_kind   (o_res.out_kind),
        .o_out_value  (o_res.out_value),
        .o_overflowed (o_res.overflowed),
        .o_run_end    (o_res.run_end)
    );

`ifndef SYNTHESIS
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_res.valid && i_req.ready))
        else $error("Input accepted while a result is pending.");

    a_end_on_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid |-> (o_res.run_end == (o_res.out_kind == pli_pkg::KIND_COUNT)))
        else $error("Run end flag does not match the item kind.");

    a_idle_after_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res.valid && o_res.ready && o_res.run_end) |=> i_req.ready)
        else $error("Unit not ready after the count item.");
`endif

endmodule

FILE: tb/tb_posting_list_intersection_unit.sv
// Self-checking testbench of posting_list_intersection_unit with randomized queries and stalls.
module tb_posting_list_intersection_unit;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [pli_pkg::REQ_W-1:0] REQ_UNUSED = 2'd3;
    localparam int ITEM_TARGET  = 420;
    localparam int LIMIT_CYCLES = 1000000;
    localparam int LONG_HOLD    = 400;

    typedef struct packed {
        logic                     is_count;
        logic [pli_pkg::ID_W-1:0] value;
        logic                     ovf;
        logic                     run_end;
    } t_result;

    class match_board;
        logic [pli_pkg::ID_W-1:0] stored_id[pli_pkg::CAPACITY];
        bit                       stored_valid[pli_pkg::CAPACITY];
        bit                       stored_hit[pli_pkg::CAPACITY];
        bit                       first_done;
        bit                       ovf;
        t_result                  pending[$];
        int                       mismatches;
        int                       checked;
        int                       queries;
        int                       overflow_queries;

        function new();
            clear();
        endfunction

        function void clear();
            foreach (stored_id[i]) begin
                stored_id[i]    = '0;
                stored_valid[i] = 1'b0;
                stored_hit[i]   = 1'b0;
            end
            first_done = 1'b0;
            ovf        = 1'b0;
        endfunction

        function void note_request(logic [pli_pkg::REQ_W-1:0] req,
                                   logic [pli_pkg::ID_W-1:0] id);
            logic [pli_pkg::ID_W-1:0] survivors[$];
            t_result                  r;
            bit                       found;
            int                       free_slot;
            case (req)
                pli_pkg::REQ_ELEM: begin
                    if (!first_done) begin
                        found     = 1'b0;
                        free_slot = -1;
                        for (int i = 0; i < pli_pkg::CAPACITY; i++) begin
                            if (stored_valid[i] && stored_id[i] == id) found = 1'b1;
                            if (!stored_valid[i] && free_slot < 0) free_slot = i;
                        end
                        if (!found) begin
                            if (free_slot < 0) begin
                                ovf = 1'b1;
                            end else begin
                                stored_id[free_slot]    = id;
                                stored_valid[free_slot] = 1'b1;
                                stored_hit[free_slot]   = 1'b0;
                            end
                        end
                    end else begin
                        for (int i = 0; i < pli_pkg::CAPACITY; i++)
                            if (stored_valid[i] && stored_id[i] == id) stored_hit[i] = 1'b1;
                    end
                end
                pli_pkg::REQ_END_LIST: begin
                    for (int i = 0; i < pli_pkg::CAPACITY; i++) begin
                        if (first_done) stored_valid[i] = stored_valid[i] && stored_hit[i];
                        stored_hit[i] = 1'b0;
                    end
                    first_done = 1'b1;
                end
                pli_pkg::REQ_END_QUERY: begin
                    for (int i = 0; i < pli_pkg::CAPACITY; i++)
                        if (stored_valid[i]) survivors = {survivors, stored_id[i]};
                    survivors.sort();
                    foreach (survivors[i]) begin
                        r.is_count = pli_pkg::KIND_ID;
                        r.value    = survivors[i];
                        r.ovf      = ovf;
                        r.run_end  = 1'b0;
                        pending    = {pending, r};
                    end
                    r.is_count = pli_pkg::KIND_COUNT;
                    r.value    = pli_pkg::ID_W'(survivors.size());
                    r.ovf      = ovf;
                    r.run_end  = 1'b1;
                    pending    = {pending, r};
                    queries++;
                    if (ovf) overflow_queries++;
                    clear();
                end
                default: ;
            endcase
        endfunction

        function void check_result(t_result got);
            t_result want;
            checked++;
            if (pending.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result: kind %0b value %08h ovf %0b end %0b",
                             got.is_count, got.value, got.ovf, got.run_end);
            end else begin
                want = pending.pop_front();
                if (got.is_count !== want.is_count || got.value !== want.value ||
                    got.ovf !== want.ovf || got.run_end !== want.run_end) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("result mismatch: expected kind %0b value %08h ovf %0b end %0b",
                                 want.is_count, want.value, want.ovf, want.run_end);
                        $display("                 got kind %0b value %08h ovf %0b end %0b",
                                 got.is_count, got.value, got.ovf, got.run_end);
                    end
                end
            end
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;

    pli_req_if req_ch();
    pli_res_if res_ch();

    posting_list_intersection_unit u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch),
        .o_res   (res_ch)
    );

    match_board sb;
    int         items_sent;
    bit         quiet;
    bit         hold_long;

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    initial begin
        repeat (LIMIT_CYCLES) @(posedge i_clk);
        $display("status: fail");
        $finish;
    end

    initial begin
        res_ch.ready <= 1'b0;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if (hold_long) begin
                hold_long = 1'b0;
                res_ch.ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge i_clk);
            end else if (!quiet && $urandom_range(0, 3) == 0) begin
                res_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 13)) @(posedge i_clk);
            end else begin
                res_ch.ready <= 1'b1;
                repeat ($urandom_range(1, 24)) @(posedge i_clk);
            end
        end
    end

    always @(posedge i_clk) begin
        t_result got;
        if (i_rst_n && res_ch.valid && res_ch.ready) begin
            got.is_count = res_ch.out_kind;
            got.value    = res_ch.out_value;
            got.ovf      = res_ch.overflowed;
            got.run_end  = res_ch.run_end;
            sb.check_result(got);
        end
    end

    task automatic offer(input logic [pli_pkg::REQ_W-1:0] req,
                         input logic [pli_pkg::ID_W-1:0] id);
        if (!quiet && $urandom_range(0, 4) == 0) begin
            req_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 13)) @(posedge i_clk);
        end
        req_ch.valid    <= 1'b1;
        req_ch.req_type <= req;
        req_ch.doc_id   <= id;
        @(posedge i_clk);
        while (!req_ch.ready) @(posedge i_clk);
        sb.note_request(req, id);
        if (req != REQ_UNUSED) items_sent++;
    endtask

    task automatic send_item(input logic [pli_pkg::REQ_W-1:0] req,
                             input logic [pli_pkg::ID_W-1:0] id);
        if ($urandom_range(0, 29) == 0) offer(REQ_UNUSED, $urandom);
        offer(req, id);
    endtask

    task automatic drain();
        req_ch.valid <= 1'b0;
        while (sb.pending.size() != 0) @(posedge i_clk);
    endtask

    function automatic logic [pli_pkg::ID_W-1:0] pick_id();
        case ($urandom_range(0, 5))
            0:       return '0;
            1:       return '1;
            2, 3:    return $urandom_range(0, 31);
            default: return $urandom;
        endcase
    endfunction

    task automatic run_query(input int first_len, input bit keep_marker);
        logic [pli_pkg::ID_W-1:0] pool[$];
        int                       pool_n;
        int                       n_later;
        int                       len;
        bit                       big;
        big    = first_len > 12;
        pool_n = big ? first_len + 4 : $urandom_range(1, 12);
        for (int i = 0; i < pool_n; i++)
            pool = {pool, (big ? $urandom : pick_id())};
        for (int i = 0; i < first_len; i++)
            send_item(pli_pkg::REQ_ELEM, big ? pool[i] : pool[$urandom_range(0, pool_n - 1)]);
        if (keep_marker) begin
            send_item(pli_pkg::REQ_END_LIST, $urandom);
            n_later = $urandom_range(0, 3);
            for (int l = 0; l < n_later; l++) begin
                len = $urandom_range(0, 10);
                for (int k = 0; k < len; k++)
                    send_item(pli_pkg::REQ_ELEM, ($urandom_range(0, 3) != 0) ?
                              pool[$urandom_range(0, pool_n - 1)] : pick_id());
                if (!(l == n_later - 1 && $urandom_range(0, 5) == 0))
                    send_item(pli_pkg::REQ_END_LIST, $urandom);
            end
        end
        send_item(pli_pkg::REQ_END_QUERY, $urandom);
    endtask

    initial begin
        bit held;
        bit paused;
        sb         = new();
        items_sent = 0;
        quiet      = 1'b0;
        hold_long  = 1'b0;
        held       = 1'b0;
        paused     = 1'b0;
        i_rst_n         <= 1'b0;
        req_ch.valid    <= 1'b0;
        req_ch.req_type <= pli_pkg::REQ_ELEM;
        req_ch.doc_id   <= '0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_item(pli_pkg::REQ_END_QUERY, '0);

        send_item(pli_pkg::REQ_ELEM, '1);
        send_item(pli_pkg::REQ_ELEM, '0);
        send_item(pli_pkg::REQ_ELEM, 32'd5);
        send_item(pli_pkg::REQ_ELEM, 32'd5);
        offer(REQ_UNUSED, '1);
        send_item(pli_pkg::REQ_END_LIST, $urandom);
        send_item(pli_pkg::REQ_ELEM, '0);
        send_item(pli_pkg::REQ_ELEM, '1);
        send_item(pli_pkg::REQ_ELEM, 32'd7);
        send_item(pli_pkg::REQ_END_LIST, $urandom);
        send_item(pli_pkg::REQ_ELEM, 32'd5);
        send_item(pli_pkg::REQ_END_QUERY, $urandom);

        send_item(pli_pkg::REQ_ELEM, 32'd9);
        send_item(pli_pkg::REQ_ELEM, 32'd1);
        send_item(pli_pkg::REQ_END_QUERY, '1);

        send_item(pli_pkg::REQ_ELEM, 32'd4);
        send_item(pli_pkg::REQ_END_LIST, '0);
        send_item(pli_pkg::REQ_END_LIST, '1);
        send_item(pli_pkg::REQ_END_QUERY, '0);

        run_query(pli_pkg::CAPACITY + 4, 1'b1);
        run_query(pli_pkg::CAPACITY, 1'b1);

        while (items_sent < ITEM_TARGET) begin
            if (!held && items_sent >= 150) begin
                held      = 1'b1;
                hold_long = 1'b1;
                run_query(12, 1'b1);
            end
            if (!paused && items_sent >= 280) begin
                paused = 1'b1;
                drain();
            end
            if (items_sent >= 360) quiet = 1'b1;
            run_query(($urandom_range(0, 15) == 0) ? 40 : $urandom_range(0, 10),
                      $urandom_range(0, 9) != 0);
        end

        drain();
        repeat (2 * (pli_pkg::CAPACITY + 2)) @(posedge i_clk);

        $display("covered %0d list items and markers in %0d queries, %0d with overflow",
                 items_sent, sb.queries, sb.overflow_queries);
        $display("checked %0d results, %0d mismatches", sb.checked, sb.mismatches);
        if (sb.mismatches == 0 && sb.pending.size() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

FILE: posting_list_intersection_unit.f
sv/pli_pkg.sv
sv/pli_req_if.sv
sv/pli_res_if.sv
sv/pli_ctrl.sv
sv/pli_dp.sv
sv/posting_list_intersection_unit.sv
tb/tb_posting_list_intersection_unit.sv
